[rtl/tbt_pkg.sv]
// Package: shared codes, field widths and parameter defaults for the token bucket table.
`timescale 1ns / 1ps
package tbt_pkg;

  // Field widths of the request and response words
  localparam int FUNC_W   = 2;
  localparam int SLOT_W   = 6;
  localparam int ARG_W    = 16;
  localparam int STATUS_W = 3;

  // Parameter defaults
  localparam int NUM_BUCKETS_DEF = 64;
  localparam int TOKEN_WIDTH_DEF = 16;

  // Operation codes
  localparam logic [FUNC_W-1:0] FUNC_TICK    = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_CREATE  = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_FETCH   = 2'd2;
  localparam logic [FUNC_W-1:0] FUNC_DESTROY = 2'd3;

  // Status codes
  localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
  localparam logic [STATUS_W-1:0] ST_BADARG   = 3'd1;
  localparam logic [STATUS_W-1:0] ST_NOSLOT   = 3'd2;
  localparam logic [STATUS_W-1:0] ST_NOTALLOC = 3'd3;
  localparam logic [STATUS_W-1:0] ST_BLOCK    = 3'd4;

endpackage

[rtl/tbt_req_if.sv]
// Interface: request channel (operation and its arguments).
`timescale 1ns / 1ps
interface tbt_req_if import tbt_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [FUNC_W-1:0] func;
  logic [SLOT_W-1:0] slot;
  logic [ARG_W-1:0]  rate;
  logic [ARG_W-1:0]  burst_size;
  logic [ARG_W-1:0]  amount;

  modport source (output valid, func, slot, rate, burst_size, amount, input ready);
  modport sink (input valid, func, slot, rate, burst_size, amount, output ready);
endinterface

[rtl/tbt_rsp_if.sv]
// Interface: response channel (status, assigned slot, granted tokens).
`timescale 1ns / 1ps
interface tbt_rsp_if import tbt_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [SLOT_W-1:0]   slot_out;
  logic [ARG_W-1:0]    granted;

  modport source (output valid, status, slot_out, granted, input ready);
  modport sink (input valid, status, slot_out, granted, output ready);
endinterface

[rtl/token_bucket_table_core.sv]
// Top level: token bucket table with one bucket RAM and a small sequencer.
// After reset the block clears every entry of the bucket RAM and takes no
// request meanwhile. It then handles one request word at a time; each RAM
// entry visit is a read state followed by a modify/write state through the
// shared arithmetic unit. A tick visits every entry, a create walks up from
// slot 0 to the lowest free slot (the whole table when it is full), fetch and
// destroy visit one entry, and a rejected request visits none. A finished
// response waits in an output register, and the next request is accepted while
// it is still pending.
`timescale 1ns / 1ps
module token_bucket_table_core import tbt_pkg::*; #(
  parameter int NUM_BUCKETS = NUM_BUCKETS_DEF,
  parameter int TOKEN_WIDTH = TOKEN_WIDTH_DEF
) (
  input logic        clk,
  input logic        rst,
  tbt_req_if.sink    req,
  tbt_rsp_if.source  rsp
);
  localparam int IW = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;
  localparam int EW = 1 + ARG_W + 2 * TOKEN_WIDTH;  // valid, rate, cap, tokens
  localparam int BW = (TOKEN_WIDTH > ARG_W) ? TOKEN_WIDTH : ARG_W;
  localparam logic [IW-1:0] LAST_IDX = IW'(NUM_BUCKETS - 1);
  localparam logic [BW-1:0] TOK_MAX  = BW'((64'd1 << TOKEN_WIDTH) - 64'd1);

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_READ  = 3'd2;
  localparam logic [2:0] S_MOD   = 3'd3;
  localparam logic [2:0] S_RESP  = 3'd4;

  logic [2:0]          state;
  logic [IW-1:0]       idx;
  logic [FUNC_W-1:0]   op;
  logic [ARG_W-1:0]    r_rate;
  logic [ARG_W-1:0]    r_burst;
  logic [ARG_W-1:0]    r_amount;
  logic [STATUS_W-1:0] res_status;
  logic [SLOT_W-1:0]   res_slot;
  logic [ARG_W-1:0]    res_granted;
  logic                out_valid;
  logic [STATUS_W-1:0] out_status;
  logic [SLOT_W-1:0]   out_slot;
  logic [ARG_W-1:0]    out_granted;

  logic                   ram_we;
  logic [EW-1:0]          ram_wdata;
  logic [EW-1:0]          ram_rdata;
  logic                   rd_valid;
  logic [ARG_W-1:0]       rd_rate;
  logic [TOKEN_WIDTH-1:0] rd_cap;
  logic [TOKEN_WIDTH-1:0] rd_tokens;
  logic [TOKEN_WIDTH-1:0] alu_tokens;
  logic [ARG_W-1:0]       alu_granted;
  logic [TOKEN_WIDTH-1:0] cap_sat;
  logic                   slot_bad;
  logic                   accept;
  logic                   load_out;

  // bucket entry fields
  assign rd_valid  = ram_rdata[EW-1];
  assign rd_rate   = ram_rdata[EW-2 -: ARG_W];
  assign rd_cap    = ram_rdata[2*TOKEN_WIDTH-1 -: TOKEN_WIDTH];
  assign rd_tokens = ram_rdata[TOKEN_WIDTH-1:0];

  // handshake
  assign req.ready = (state == S_IDLE);
  assign accept    = req.valid && req.ready;
  assign load_out  = (state == S_RESP) && (!out_valid || rsp.ready);
  assign slot_bad  = (32'(req.slot) >= NUM_BUCKETS);
  assign cap_sat   = (BW'(r_burst) > TOK_MAX) ? TOKEN_WIDTH'(TOK_MAX)
                                              : TOKEN_WIDTH'(r_burst);

  assign rsp.valid    = out_valid;
  assign rsp.status   = out_status;
  assign rsp.slot_out = out_slot;
  assign rsp.granted  = out_granted;

  tbt_ram #(
    .WIDTH (EW),
    .DEPTH (NUM_BUCKETS)
  ) u_bucket_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (idx),
    .wdata (ram_wdata),
    .re    (state == S_READ),
    .raddr (idx),
    .rdata (ram_rdata)
  );

  tbt_alu #(
    .TOKEN_WIDTH (TOKEN_WIDTH)
  ) u_alu (
    .func       (op),
    .tokens     (rd_tokens),
    .rate       (rd_rate),
    .cap        (rd_cap),
    .amount     (r_amount),
    .new_tokens (alu_tokens),
    .granted    (alu_granted)
  );

  // RAM write-back
  always_comb begin
    ram_we    = 1'b0;
    ram_wdata = '0;
    if (state == S_CLEAR) begin
      ram_we = 1'b1;
    end else if (state == S_MOD) begin
      case (op)
        FUNC_TICK: begin
          ram_we    = rd_valid;
          ram_wdata = {1'b1, rd_rate, rd_cap, alu_tokens};
        end
        FUNC_CREATE: begin
          ram_we    = !rd_valid;
          ram_wdata = {1'b1, r_rate, cap_sat, {TOKEN_WIDTH{1'b0}}};
        end
        FUNC_FETCH: begin
          ram_we    = rd_valid && (rd_tokens != '0);
          ram_wdata = {1'b1, rd_rate, rd_cap, alu_tokens};
        end
        default: begin
          ram_we    = rd_valid;
          ram_wdata = {1'b0, rd_rate, rd_cap, rd_tokens};
        end
      endcase
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      idx   <= '0;
    end else begin
      unique case (state)
        S_CLEAR: begin
          if (idx == LAST_IDX) begin
            idx   <= '0;
            state <= S_IDLE;
          end else begin
            idx <= idx + 1'b1;
          end
        end
        S_IDLE: begin
          if (accept) begin
            case (req.func)
              FUNC_TICK: begin
                idx   <= '0;
                state <= S_READ;
              end
              FUNC_CREATE: begin
                idx   <= '0;
                state <= ((req.rate == '0) || (req.burst_size == '0)) ? S_RESP : S_READ;
              end
              FUNC_FETCH: begin
                idx   <= IW'(32'(req.slot));
                state <= (slot_bad || (req.amount == '0)) ? S_RESP : S_READ;
              end
              default: begin
                idx   <= IW'(32'(req.slot));
                state <= slot_bad ? S_RESP : S_READ;
              end
            endcase
          end
        end
        S_READ: begin
          state <= S_MOD;
        end
        S_MOD: begin
          case (op) inside
            FUNC_TICK, FUNC_CREATE: begin
              if ((op == FUNC_CREATE && !rd_valid) || idx == LAST_IDX) begin
                state <= S_RESP;
              end else begin
                idx   <= idx + 1'b1;
                state <= S_READ;
              end
            end
            default: begin
              state <= S_RESP;
            end
          endcase
        end
        S_RESP: begin
          if (load_out) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // request capture and result fields
  always_ff @(posedge clk) begin
    if (accept) begin
      op          <= req.func;
      r_rate      <= req.rate;
      r_burst     <= req.burst_size;
      r_amount    <= req.amount;
      res_slot    <= '0;
      res_granted <= '0;
      case (req.func)
        FUNC_CREATE: begin
          res_status <= ((req.rate == '0) || (req.burst_size == '0)) ? ST_BADARG : ST_OK;
        end
        FUNC_FETCH: begin
          res_status <= (slot_bad || (req.amount == '0)) ? ST_BADARG : ST_OK;
        end
        FUNC_DESTROY: begin
          res_status <= slot_bad ? ST_BADARG : ST_OK;
        end
        default: begin
          res_status <= ST_OK;
        end
      endcase
    end else if (state == S_MOD) begin
      case (op)
        FUNC_CREATE: begin
          if (!rd_valid) begin
            res_slot <= SLOT_W'(idx);
          end else if (idx == LAST_IDX) begin
            res_status <= ST_NOSLOT;
          end
        end
        FUNC_FETCH: begin
          if (!rd_valid) begin
            res_status <= ST_NOTALLOC;
          end else if (rd_tokens == '0) begin
            res_status <= ST_BLOCK;
          end else begin
            res_granted <= alu_granted;
          end
        end
        FUNC_DESTROY: begin
          if (!rd_valid) begin
            res_status <= ST_NOTALLOC;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // output word register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_status  <= res_status;
      out_slot    <= res_slot;
      out_granted <= res_granted;
    end
  end
endmodule

[rtl/tbt_ram.sv]
// Generic simple dual-port RAM with registered read data.
`timescale 1ns / 1ps
module tbt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule

[rtl/tbt_alu.sv]
// Shared token arithmetic: refill with cap saturation, or grant and debit.
`timescale 1ns / 1ps
module tbt_alu import tbt_pkg::*; #(
  parameter int TOKEN_WIDTH = TOKEN_WIDTH_DEF
) (
  input  logic [FUNC_W-1:0]      func,
  input  logic [TOKEN_WIDTH-1:0] tokens,
  input  logic [ARG_W-1:0]       rate,
  input  logic [TOKEN_WIDTH-1:0] cap,
  input  logic [ARG_W-1:0]       amount,
  output logic [TOKEN_WIDTH-1:0] new_tokens,
  output logic [ARG_W-1:0]       granted
);
  // sum width: covers tokens + rate without overflow
  localparam int SW = ((TOKEN_WIDTH > ARG_W) ? TOKEN_WIDTH : ARG_W) + 1;

  logic [SW-1:0] opa;
  logic [SW-1:0] opb;
  logic [SW-1:0] sum;
  logic          a_ge_b;

  // one adder, one comparator and one subtractor, operands picked by the operation
  always_comb begin
    opa = SW'(tokens);
    opb = (func == FUNC_TICK) ? SW'(cap) : SW'(amount);
    sum = SW'(tokens) + SW'(rate);
    if (func == FUNC_TICK) begin
      opa = sum;
    end
    a_ge_b = (opa >= opb);

    if (func == FUNC_TICK) begin
      // refill, clamp at the cap
      granted    = '0;
      new_tokens = (a_ge_b && (opa != opb)) ? cap : TOKEN_WIDTH'(sum);
    end else begin
      // grant min(amount, tokens); tokens below amount fit in ARG_W
      granted    = a_ge_b ? amount : ARG_W'(tokens);
      new_tokens = tokens - TOKEN_WIDTH'(granted);
    end
  end
endmodule
